### rtl/atsp_pkg.sv
package atsp_pkg;

  // input beat: one raw three-axis sample
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } atsp_in_t;

  // result beat
  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic [14:0]        servo_pulse_us;
    logic               tilt_alert;
  } atsp_out_t;

  // configuration register indexes
  localparam logic [1:0] CFG_ALERT_THR = 2'd0;
  localparam logic [1:0] CFG_PULSE_MIN = 2'd1;
  localparam logic [1:0] CFG_PULSE_MAX = 2'd2;

  localparam logic [6:0]  THR_RST  = 7'd30;
  localparam logic [14:0] PMIN_RST = 15'd500;
  localparam logic [14:0] PMAX_RST = 15'd2500;

  // fixed-point formats
  localparam int GUARD_BITS = 14;   // numerator / root scale
  localparam int ACC_FRAC   = 20;   // CORDIC angle accumulator fraction bits
  localparam int TAB_LEN    = 24;   // most CORDIC iterations supported
  localparam int RT_W       = 30;   // root bits of sqrt((a^2+b^2) << 28)
  localparam int RAD_W      = 62;   // radicand / remainder width
  localparam int XW         = 33;   // CORDIC x/y width
  localparam int ZW         = 29;   // CORDIC angle accumulator width

  // divide by 45: multiply by round-down reciprocal, then one correction
  localparam logic [15:0] RECIP_45 = 16'd46603;
  localparam int          RECIP_SH = 21;
  localparam logic [5:0]  DIV_45   = 6'd45;

  // atan(2^-i) in degrees, 20 fraction bits
  localparam logic [26:0] ATAN_TAB [TAB_LEN] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
    27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
    27'd234682,   27'd117342,   27'd58671,    27'd29335,
    27'd14668,    27'd7334,     27'd3667,     27'd1833,
    27'd917,      27'd458,      27'd229,      27'd115,
    27'd57,       27'd29,       27'd14,       27'd7
  };

endpackage

### rtl/atsp_angle.sv
// atan2(num, sqrt(a^2+b^2)) in degrees: pipelined square root, then pipelined
// vectoring CORDIC, then round and clamp. One sample per cycle, no stall.
module atsp_angle import atsp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic                                clk,
  input  logic signed [15:0]                  num_i,
  input  logic signed [15:0]                  a_i,
  input  logic signed [15:0]                  b_i,
  output logic signed [ANGLE_FRAC_BITS+7:0]   angle_o
);

  localparam int AW    = ANGLE_FRAC_BITS + 8;
  localparam int NCS   = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
  localparam int RS    = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int LIM_I = 90 << ANGLE_FRAC_BITS;

  // squares
  logic signed [31:0] pa, pb;
  logic [30:0]        sqa_r, sqb_r;
  logic signed [15:0] num_sq_r;

  assign pa = 32'(a_i) * 32'(a_i);
  assign pb = 32'(b_i) * 32'(b_i);

  always_ff @(posedge clk) begin
    sqa_r    <= pa[30:0];
    sqb_r    <= pb[30:0];
    num_sq_r <= num_i;
  end

  // square root, one root bit per stage
  logic [RAD_W-1:0]   rem_r  [RT_W+1];
  logic [RT_W-1:0]    root_r [RT_W+1];
  logic signed [15:0] numq_r [RT_W+1];
  logic [31:0]        sum;

  assign sum = {1'b0, sqa_r} + {1'b0, sqb_r};

  always_ff @(posedge clk) begin
    rem_r[0]  <= {{(RAD_W-32-2*GUARD_BITS){1'b0}}, sum, {(2*GUARD_BITS){1'b0}}};
    root_r[0] <= '0;
    numq_r[0] <= num_sq_r;
  end

  for (genvar g = 0; g < RT_W; g++) begin : g_sqrt
    localparam int K = RT_W - 1 - g;
    logic [RAD_W-1:0] trial;
    logic [RAD_W-1:0] one_w;

    assign one_w = {{(RAD_W-1){1'b0}}, 1'b1};
    assign trial = ({{(RAD_W-RT_W){1'b0}}, root_r[g]} << (K + 1)) | (one_w << (2 * K));

    always_ff @(posedge clk) begin
      if (rem_r[g] >= trial) begin
        rem_r[g+1]  <= rem_r[g] - trial;
        root_r[g+1] <= root_r[g] | (RT_W'(1) << K);
      end else begin
        rem_r[g+1]  <= rem_r[g];
        root_r[g+1] <= root_r[g];
      end
      numq_r[g+1] <= numq_r[g];
    end
  end

  // CORDIC load and vectoring iterations
  logic signed [XW-1:0] cx_r  [NCS+1];
  logic signed [XW-1:0] cy_r  [NCS+1];
  logic signed [ZW-1:0] cz_r  [NCS+1];
  logic                 cnz_r [NCS+1];

  always_ff @(posedge clk) begin
    cx_r[0]  <= {{(XW-RT_W){1'b0}}, root_r[RT_W]};
    cy_r[0]  <= {{(XW-16-GUARD_BITS){numq_r[RT_W][15]}}, numq_r[RT_W],
                 {GUARD_BITS{1'b0}}};
    cz_r[0]  <= '0;
    cnz_r[0] <= |numq_r[RT_W];
  end

  for (genvar i = 0; i < NCS; i++) begin : g_cordic
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] da;

    assign dx = cy_r[i] >>> i;
    assign dy = cx_r[i] >>> i;
    assign da = signed'({{(ZW-27){1'b0}}, ATAN_TAB[i]});

    always_ff @(posedge clk) begin
      if (!cy_r[i][XW-1]) begin
        cx_r[i+1] <= cx_r[i] + dx;
        cy_r[i+1] <= cy_r[i] - dy;
        cz_r[i+1] <= cz_r[i] + da;
      end else begin
        cx_r[i+1] <= cx_r[i] - dx;
        cy_r[i+1] <= cy_r[i] + dy;
        cz_r[i+1] <= cz_r[i] - da;
      end
      cnz_r[i+1] <= cnz_r[i];
    end
  end

  // round to output fraction bits, clamp to +-90 degrees
  logic signed [ZW-1:0] zr, lim_p, lim_n, zc;
  logic signed [AW-1:0] angle_r;

  assign lim_p = ZW'(LIM_I);
  assign lim_n = -lim_p;
  assign zr    = (cz_r[NCS] + ZW'(1 << (RS - 1))) >>> RS;

  always_comb begin
    zc = zr;
    if (zr > lim_p) zc = lim_p;
    if (zr < lim_n) zc = lim_n;
  end

  always_ff @(posedge clk) begin
    angle_r <= cnz_r[NCS] ? AW'(zc) : '0;
  end

  assign angle_o = angle_r;

endmodule

### rtl/accel_tilt_to_servo_pulse.sv
// Pipeline from start to out_valid: the 30-stage square root, the CORDIC stages,
// angle rounding and 4 pulse-mapping stages.
// Throughput: one sample per cycle; busy is always low.
// Results appear for one cycle on out_valid; the receiver cannot stall.
// Reset (synchronous, rst_n low) clears the valid pipeline and restores the
// registers: threshold 30 degrees, pulse 500..2500 us.
module accel_tilt_to_servo_pulse import atsp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  atsp_in_t    in_data,
  output logic        out_valid,
  output atsp_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [14:0] cfg_wdata
);

  localparam int AW      = ANGLE_FRAC_BITS + 8;
  localparam int NCS     = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
  localparam int LATENCY = 38 + NCS;
  localparam int PW      = AW + 15;
  localparam int OFS_90  = 90 << ANGLE_FRAC_BITS;
  localparam int FULL    = 180 << ANGLE_FRAC_BITS;

  assign busy = 1'b0;

  // configuration registers
  logic [6:0]  thr_r;
  logic [14:0] pmin_r, pmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RST;
      pmin_r <= PMIN_RST;
      pmax_r <= PMAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ALERT_THR: thr_r  <= cfg_wdata[6:0];
        CFG_PULSE_MIN: pmin_r <= cfg_wdata;
        CFG_PULSE_MAX: pmax_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid bits alongside the data pipeline
  logic [LATENCY-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LATENCY-2:0], start && !busy};
  end

  assign out_valid = vld_r[LATENCY-1];

  // pitch and roll
  logic signed [AW-1:0] pitch, roll;

  atsp_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk    (clk),
    .num_i  (in_data.accel_x),
    .a_i    (in_data.accel_y),
    .b_i    (in_data.accel_z),
    .angle_o(pitch)
  );

  atsp_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk    (clk),
    .num_i  (in_data.accel_y),
    .a_i    (in_data.accel_x),
    .b_i    (in_data.accel_z),
    .angle_o(roll)
  );

  // stage 1: servo angle, alert
  logic signed [AW:0]   ang_s, ap, ar, thr_s;
  logic [AW-1:0]        ang_c;
  logic [AW-1:0]        ang1_r;
  logic signed [AW-1:0] pitch1_r, roll1_r;
  logic                 alert1_r;

  assign ang_s = (AW+1)'(pitch) + (AW+1)'(OFS_90);
  assign ap    = pitch[AW-1] ? -(AW+1)'(pitch) : (AW+1)'(pitch);
  assign ar    = roll[AW-1]  ? -(AW+1)'(roll)  : (AW+1)'(roll);
  assign thr_s = signed'((AW+1)'({thr_r, {ANGLE_FRAC_BITS{1'b0}}}));

  always_comb begin
    ang_c = ang_s[AW-1:0];
    if (ang_s < 0) ang_c = '0;
    if (ang_s > (AW+1)'(FULL)) ang_c = AW'(FULL);
  end

  always_ff @(posedge clk) begin
    ang1_r   <= ang_c;
    pitch1_r <= pitch;
    roll1_r  <= roll;
    alert1_r <= (ap > thr_s) || (ar > thr_s);
  end

  // stage 2: angle times span, drop the power-of-two part of the divisor
  logic [14:0]          span;
  logic [PW-1:0]        prod;
  logic [20:0]          m2_r;
  logic signed [AW-1:0] pitch2_r, roll2_r;
  logic                 alert2_r;

  assign span = pmax_r - pmin_r;
  assign prod = PW'(ang1_r) * PW'(span);

  always_ff @(posedge clk) begin
    m2_r     <= 21'(prod >> (ANGLE_FRAC_BITS + 2));
    pitch2_r <= pitch1_r;
    roll2_r  <= roll1_r;
    alert2_r <= alert1_r;
  end

  // stage 3: quotient estimate for divide by 45
  logic [36:0]          qp;
  logic [20:0]          m3_r;
  logic [15:0]          q0_r;
  logic signed [AW-1:0] pitch3_r, roll3_r;
  logic                 alert3_r;

  assign qp = 37'(m2_r) * 37'(RECIP_45);

  always_ff @(posedge clk) begin
    m3_r     <= m2_r;
    q0_r     <= qp[RECIP_SH+15:RECIP_SH];
    pitch3_r <= pitch2_r;
    roll3_r  <= roll2_r;
    alert3_r <= alert2_r;
  end

  // stage 4: correct quotient, offset and clamp the pulse
  logic [21:0] rem45;
  logic [15:0] q, psum;
  logic [14:0] pulse;
  atsp_out_t   out_r;

  assign rem45 = {1'b0, m3_r} - 22'(q0_r) * 22'(DIV_45);
  assign q     = q0_r + 16'(rem45 >= 22'(DIV_45));
  assign psum  = {1'b0, pmin_r} + q;

  always_comb begin
    if (pmin_r > pmax_r || psum > {1'b0, pmax_r}) pulse = pmax_r;
    else                                          pulse = psum[14:0];
  end

  always_ff @(posedge clk) begin
    out_r.pitch_angle    <= 16'(pitch3_r);
    out_r.roll_angle     <= 16'(roll3_r);
    out_r.servo_pulse_us <= pulse;
    out_r.tilt_alert     <= alert3_r;
  end

  assign out_data = out_r;

endmodule

### rtl/atsp_checker.sv
// Port-level checks for the tilt block
module atsp_checker import atsp_pkg::*; #(
  parameter int LAT = 54
) (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input atsp_in_t  in_data,
  input logic      out_valid,
  input atsp_out_t out_data
);

  // block always takes a beat
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every result beat comes from a start a fixed latency earlier
  a_fixed_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching start");

  // zero X axis gives zero pitch
  a_zero_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.accel_x == 16'sd0) |->
      ##LAT (!out_valid || out_data.pitch_angle == 16'sd0))
    else $error("nonzero pitch for zero X");

  // level attitude never alerts
  a_level_no_alert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.pitch_angle == 16'sd0 && out_data.roll_angle == 16'sd0)
      |-> !out_data.tilt_alert)
    else $error("alert with zero angles");

endmodule

bind accel_tilt_to_servo_pulse atsp_checker #(.LAT(LATENCY)) u_atsp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_data (out_data)
);
